// ----- src/bsdp_pkg.sv -----
// ============================================================================
// bsdp_pkg: shared types and constants
// Widths, float encodings and the working float frame that the block-scaled
// int8 dot product unit passes between its normaliser and rounder.
// ============================================================================
package bsdp_pkg;

  localparam int LANES      = 4;
  localparam int LANE_ELEMS = 8;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = LANE_ELEMS * BYTE_W;
  localparam int PROD_W     = 16;
  localparam int LANE_SUM_W = 19;
  localparam int ISUM_W     = 21;
  localparam int MAG_W      = 20;
  localparam int MANT_W     = 24;
  localparam int EXP_W      = 12;
  localparam int FRAME_W    = 64;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [7:0]  EXP_MAX   = 8'hFF;

  // Value of a frame is m * 2^(e - 63); normalised when m[63] is set.
  typedef struct packed {
    logic signed [EXP_W-1:0] e;
    logic [FRAME_W-1:0]      m;
  } bsdp_xf_t;

  typedef struct packed {
    logic     sign;
    logic     sticky;
    bsdp_xf_t x;
  } bsdp_rnd_t;

  function automatic logic [MANT_W-1:0] f_mant(input logic [31:0] f);
    return {|f[30:23], f[22:0]};
  endfunction

  function automatic logic [7:0] f_exp_eff(input logic [31:0] f);
    return (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
  endfunction

  function automatic logic f_is_nan(input logic [31:0] f);
    return (f[30:23] == EXP_MAX) && (|f[22:0]);
  endfunction

  function automatic logic f_is_inf(input logic [31:0] f);
    return (f[30:23] == EXP_MAX) && !(|f[22:0]);
  endfunction

  function automatic logic f_is_zero(input logic [31:0] f);
    return !(|f[30:0]);
  endfunction

endpackage

// ----- src/block_scaled_int8_dot_product_unit.sv -----
// ============================================================================
// block_scaled_int8_dot_product_unit: block-scaled int8 dot product
// Takes one quantisation block per word and accumulates its scaled integer
// dot product into a single-precision running sum.
// ============================================================================
// Input channel: one word carries 32 activation bytes, 32 weight bytes, the
// two single-precision block scales and a last flag. Four lanes form the
// byte products and lane totals, a merge stage adds them exactly, the scale
// product is rounded to single, and one fused multiply-add with a single
// rounding updates the running sum.
// The word rate is set by the shared normaliser, which runs four times per
// word (scale product, product operand, running sum, sum), and by the
// steps lane, merge, scale rounding, multiply, load, align, add and final
// rounding, plus the idle state in which the word is taken.
// in_ready is high only while no word is in progress.
// Output channel: a word flagged last yields one result; other words yield
// nothing. The result waits in an output register; a stalled receiver holds
// only the next last word, in its final rounding step, until the register
// is free.
// Reset: the running sum returns to +0.0, no result is pending and the
// block is ready. After each result the running sum returns to +0.0.
// ============================================================================
module block_scaled_int8_dot_product_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_act_word0,
  input  logic [63:0] in_act_word1,
  input  logic [63:0] in_act_word2,
  input  logic [63:0] in_act_word3,
  input  logic [63:0] in_wgt_word0,
  input  logic [63:0] in_wgt_word1,
  input  logic [63:0] in_wgt_word2,
  input  logic [63:0] in_wgt_word3,
  input  logic [31:0] in_act_scale,
  input  logic [31:0] in_wgt_scale,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_dot_value
);
  import bsdp_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LSUM = 4'd1;
  localparam logic [3:0] ST_MRG  = 4'd2;
  localparam logic [3:0] ST_SNRM = 4'd3;
  localparam logic [3:0] ST_SRND = 4'd4;
  localparam logic [3:0] ST_FMUL = 4'd5;
  localparam logic [3:0] ST_PLD  = 4'd6;
  localparam logic [3:0] ST_PNRM = 4'd7;
  localparam logic [3:0] ST_RNRM = 4'd8;
  localparam logic [3:0] ST_ALGN = 4'd9;
  localparam logic [3:0] ST_ADD  = 4'd10;
  localparam logic [3:0] ST_ANRM = 4'd11;
  localparam logic [3:0] ST_ARND = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       accept;

  logic        out_valid_r;
  logic [31:0] out_data_r;

  // ---------------- lanes and merge ----------------
  logic [WORD_W-1:0]            act_words [LANES];
  logic [WORD_W-1:0]            wgt_words [LANES];
  logic signed [LANE_SUM_W-1:0] lane_sum  [LANES];
  logic signed [ISUM_W-1:0]     isum_nxt;
  logic signed [ISUM_W-1:0]     isum_r;

  assign act_words[0] = in_act_word0;
  assign act_words[1] = in_act_word1;
  assign act_words[2] = in_act_word2;
  assign act_words[3] = in_act_word3;
  assign wgt_words[0] = in_wgt_word0;
  assign wgt_words[1] = in_wgt_word1;
  assign wgt_words[2] = in_wgt_word2;
  assign wgt_words[3] = in_wgt_word3;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bsdp_lane u_lane (
      .clk    (clk),
      .load_i (accept),
      .act_i  (act_words[g]),
      .wgt_i  (wgt_words[g]),
      .sum_o  (lane_sum[g])
    );
  end

  always_comb begin
    isum_nxt = '0;
    for (int k = 0; k < LANES; k++) begin
      isum_nxt = isum_nxt + ISUM_W'(lane_sum[k]);
    end
  end

  // ---------------- scale product, captured at acceptance ----------------
  logic                    a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic                    sc_sign_nxt;
  logic [2*MANT_W-1:0]     sc_prod_nxt;
  logic signed [EXP_W-1:0] sc_e_nxt;
  logic                    sc_gen_nxt;
  logic [31:0]             sc_special_nxt;

  logic                    last_r;
  logic                    sc_sign_r;
  logic [2*MANT_W-1:0]     sc_prod_r;
  logic signed [EXP_W-1:0] sc_e_r;
  logic                    sc_gen_r;
  logic [31:0]             sc_special_r;
  logic [31:0]             scale_r;

  always_comb begin
    a_nan       = f_is_nan(in_act_scale);
    a_inf       = f_is_inf(in_act_scale);
    a_zero      = f_is_zero(in_act_scale);
    b_nan       = f_is_nan(in_wgt_scale);
    b_inf       = f_is_inf(in_wgt_scale);
    b_zero      = f_is_zero(in_wgt_scale);
    sc_sign_nxt = in_act_scale[31] ^ in_wgt_scale[31];
    sc_prod_nxt = f_mant(in_act_scale) * f_mant(in_wgt_scale);
    sc_e_nxt    = $signed({4'b0, f_exp_eff(in_act_scale)})
                + $signed({4'b0, f_exp_eff(in_wgt_scale)}) - 12'sd237;
    sc_gen_nxt     = 1'b0;
    sc_special_nxt = '0;
    priority if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      sc_special_nxt = CANON_NAN;
    end else if (a_inf || b_inf) begin
      sc_special_nxt = {sc_sign_nxt, EXP_MAX, 23'b0};
    end else if (a_zero || b_zero) begin
      sc_special_nxt = {sc_sign_nxt, 31'b0};
    end else begin
      sc_gen_nxt = 1'b1;
    end
  end

  // ---------------- product operand and special cases ----------------
  logic                    isum_neg;
  logic [ISUM_W-1:0]       isum_mag;
  logic [MAG_W+MANT_W-1:0] pm_nxt;
  logic signed [EXP_W-1:0] p_e_nxt;
  logic                    p_sign_nxt;
  logic                    s_nan, s_inf, s_zero, r_nan, r_inf, r_zero, isum_zero;
  logic                    fma_gen_nxt;
  logic [31:0]             fma_special_nxt;

  logic [MAG_W+MANT_W-1:0] pm_r;
  logic signed [EXP_W-1:0] p_e_r;
  logic                    p_sign_r;
  logic                    fma_gen_r;
  logic [31:0]             fma_special_r;
  logic                    r_zero_r;
  logic [31:0]             run_r;

  always_comb begin
    isum_neg   = isum_r[ISUM_W-1];
    isum_mag   = isum_neg ? ISUM_W'(-isum_r) : ISUM_W'(isum_r);
    pm_nxt     = isum_mag[MAG_W-1:0] * f_mant(scale_r);
    p_e_nxt    = $signed({4'b0, f_exp_eff(scale_r)}) - 12'sd87;
    p_sign_nxt = isum_neg ^ scale_r[31];
    s_nan      = f_is_nan(scale_r);
    s_inf      = f_is_inf(scale_r);
    s_zero     = f_is_zero(scale_r);
    r_nan      = f_is_nan(run_r);
    r_inf      = f_is_inf(run_r);
    r_zero     = f_is_zero(run_r);
    isum_zero  = (isum_r == '0);
    fma_gen_nxt     = 1'b0;
    fma_special_nxt = run_r;
    priority if (s_nan || r_nan || (s_inf && isum_zero)
                 || (s_inf && r_inf && (p_sign_nxt != run_r[31]))) begin
      fma_special_nxt = CANON_NAN;
    end else if (s_inf) begin
      fma_special_nxt = {p_sign_nxt, EXP_MAX, 23'b0};
    end else if (r_inf) begin
      fma_special_nxt = run_r;
    end else if (isum_zero || s_zero) begin
      // Adding an exact zero leaves the sum alone; two zeros follow the sign rule.
      fma_special_nxt = r_zero ? {p_sign_nxt & run_r[31], 31'b0} : run_r;
    end else begin
      fma_gen_nxt = 1'b1;
    end
  end

  // ---------------- shared normaliser and rounder ----------------
  bsdp_xf_t  norm_in;
  bsdp_xf_t  norm_x;
  logic      norm_start;
  logic      norm_busy;
  logic      norm_done;
  bsdp_rnd_t rnd_in;
  logic [31:0] rnd_bits;
  bsdp_xf_t  r_frame;

  bsdp_norm u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (norm_start),
    .x_i     (norm_in),
    .x_o     (norm_x),
    .busy_o  (norm_busy),
    .done_o  (norm_done)
  );

  bsdp_round u_round (
    .r_i    (rnd_in),
    .bits_o (rnd_bits)
  );

  // ---------------- alignment and addition ----------------
  bsdp_xf_t              pn_r;
  logic                  p_big;
  bsdp_xf_t              big_sel, small_sel;
  logic [FRAME_W-1:0]    small_m;
  logic signed [EXP_W:0] dexp;
  logic [6:0]            dclamp;
  logic [127:0]          al_wide;

  bsdp_xf_t           big_r;
  logic [FRAME_W-1:0] small_r;
  logic               small_st_r;
  logic               sub_r;
  logic               res_sign_r;

  logic [FRAME_W+1:0] vsum;
  bsdp_xf_t           add_frame;
  logic               add_st_nxt;
  logic               add_st_r;
  logic               v_zero_r;

  logic [31:0] sum_bits;
  logic [31:0] new_run;
  logic        emit_ok;

  always_comb begin
    r_frame.m = {f_mant(run_r), 40'b0};
    r_frame.e = $signed({4'b0, f_exp_eff(run_r)}) - 12'sd127;

    p_big = r_zero_r || ($signed(pn_r.e) > $signed(norm_x.e))
         || ((pn_r.e == norm_x.e) && (pn_r.m >= norm_x.m));
    big_sel   = p_big ? pn_r : norm_x;
    small_sel = p_big ? norm_x : pn_r;
    small_m   = r_zero_r ? '0 : small_sel.m;
    dexp      = $signed({big_sel.e[EXP_W-1], big_sel.e})
              - $signed({small_sel.e[EXP_W-1], small_sel.e});
    dclamp    = (dexp > 13'sd127) ? 7'd127 : dexp[6:0];
    al_wide   = {small_m, 64'b0} >> dclamp;

    // The lowest bit stands for anything shifted out below the frame.
    if (sub_r) begin
      vsum = {1'b0, big_r.m, 1'b0} - {1'b0, small_r, small_st_r};
    end else begin
      vsum = {1'b0, big_r.m, 1'b0} + {1'b0, small_r, small_st_r};
    end
    if (vsum[FRAME_W+1]) begin
      add_frame.m = vsum[FRAME_W+1:2];
      add_frame.e = big_r.e + 12'sd1;
      add_st_nxt  = |vsum[1:0];
    end else begin
      add_frame.m = vsum[FRAME_W:1];
      add_frame.e = big_r.e;
      add_st_nxt  = vsum[0];
    end

    if (state_r == ST_SRND) begin
      rnd_in.sign   = sc_sign_r;
      rnd_in.sticky = 1'b0;
    end else begin
      rnd_in.sign   = res_sign_r;
      rnd_in.sticky = add_st_r;
    end
    rnd_in.x = norm_x;

    sum_bits = v_zero_r ? '0 : rnd_bits;
    new_run  = fma_gen_r ? sum_bits : fma_special_r;
    emit_ok  = !out_valid_r || out_ready;
  end

  always_comb begin
    norm_start = 1'b0;
    norm_in    = add_frame;
    unique case (state_r)
      ST_MRG: begin
        norm_start = 1'b1;
        norm_in.m  = FRAME_W'(sc_prod_r);
        norm_in.e  = sc_e_r;
      end
      ST_PLD: begin
        norm_start = 1'b1;
        norm_in.m  = FRAME_W'(pm_r);
        norm_in.e  = p_e_r;
      end
      ST_PNRM: begin
        norm_start = norm_done;
        norm_in    = r_frame;
      end
      ST_ADD: begin
        norm_start = 1'b1;
      end
      default: begin
        norm_start = 1'b0;
      end
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_LSUM;
      ST_LSUM: state_nxt = ST_MRG;
      ST_MRG:  state_nxt = ST_SNRM;
      ST_SNRM: if (norm_done) state_nxt = ST_SRND;
      ST_SRND: state_nxt = ST_FMUL;
      ST_FMUL: state_nxt = ST_PLD;
      ST_PLD:  state_nxt = ST_PNRM;
      ST_PNRM: if (norm_done) state_nxt = ST_RNRM;
      ST_RNRM: if (norm_done) state_nxt = ST_ALGN;
      ST_ALGN: state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_ANRM;
      ST_ANRM: if (norm_done) state_nxt = ST_ARND;
      ST_ARND: if (!last_r || emit_ok) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_ARND) && last_r && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_ARND) begin
        if (!last_r) begin
          run_r <= new_run;
        end else if (emit_ok) begin
          run_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r       <= in_last_block;
      sc_sign_r    <= sc_sign_nxt;
      sc_prod_r    <= sc_prod_nxt;
      sc_e_r       <= sc_e_nxt;
      sc_gen_r     <= sc_gen_nxt;
      sc_special_r <= sc_special_nxt;
    end
    if (state_r == ST_MRG) begin
      isum_r <= isum_nxt;
    end
    if (state_r == ST_SRND) begin
      scale_r <= sc_gen_r ? rnd_bits : sc_special_r;
    end
    if (state_r == ST_FMUL) begin
      pm_r          <= pm_nxt;
      p_e_r         <= p_e_nxt;
      p_sign_r      <= p_sign_nxt;
      fma_gen_r     <= fma_gen_nxt;
      fma_special_r <= fma_special_nxt;
      r_zero_r      <= r_zero;
    end
    if ((state_r == ST_PNRM) && norm_done) begin
      pn_r <= norm_x;
    end
    if (state_r == ST_ALGN) begin
      big_r      <= big_sel;
      small_r    <= al_wide[127:64];
      small_st_r <= |al_wide[63:0];
      sub_r      <= p_sign_r ^ run_r[31];
      res_sign_r <= p_big ? p_sign_r : run_r[31];
    end
    if (state_r == ST_ADD) begin
      add_st_r <= add_st_nxt;
      v_zero_r <= (vsum == '0);
    end
    if ((state_r == ST_ARND) && last_r && emit_ok) begin
      out_data_r <= new_run;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_dot_value = out_data_r;

  // ---------------- assertions ----------------
  a_norm_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    norm_start |-> !norm_busy)
    else $error("normaliser restarted while busy");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("ready stayed high after a word was taken");

  a_result_from_round: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_ARND))
    else $error("result raised outside the final rounding step");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ARND) && last_r && emit_ok) |=> (run_r == '0))
    else $error("running sum not cleared after a result");

  a_no_result_mid_block: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ARND) && !last_r && !out_valid_r) |=> !out_valid_r)
    else $error("result produced for a word not flagged last");

endmodule

// ----- src/bsdp_lane.sv -----
// ============================================================================
// bsdp_lane: one int8 multiply lane group
// Eight signed byte products of one activation word and one weight word,
// registered, then summed into a registered lane total.
// ============================================================================
module bsdp_lane (
  input  logic                                  clk,
  input  logic                                  load_i,
  input  logic [bsdp_pkg::WORD_W-1:0]           act_i,
  input  logic [bsdp_pkg::WORD_W-1:0]           wgt_i,
  output logic signed [bsdp_pkg::LANE_SUM_W-1:0] sum_o
);
  import bsdp_pkg::*;

  logic signed [PROD_W-1:0]     prod_r [LANE_ELEMS];
  logic signed [LANE_SUM_W-1:0] sum_r;
  logic signed [LANE_SUM_W-1:0] sum_nxt;

  always_ff @(posedge clk) begin
    if (load_i) begin
      for (int k = 0; k < LANE_ELEMS; k++) begin
        prod_r[k] <= $signed(act_i[k*BYTE_W +: BYTE_W]) * $signed(wgt_i[k*BYTE_W +: BYTE_W]);
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < LANE_ELEMS; k++) begin
      sum_nxt = sum_nxt + LANE_SUM_W'(prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign sum_o = sum_r;

endmodule

// ----- src/bsdp_norm.sv -----
// ============================================================================
// bsdp_norm: iterative normaliser
// Shifts a 64-bit frame left until its top bit is set, trying 32, 16, 8, 4,
// 2 and 1 positions in turn, and adjusts the exponent.
// ============================================================================
module bsdp_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_i,
  input  bsdp_pkg::bsdp_xf_t  x_i,
  output bsdp_pkg::bsdp_xf_t  x_o,
  output logic                busy_o,
  output logic                done_o
);
  import bsdp_pkg::*;

  localparam int STEPS = 6;

  bsdp_xf_t   x_r, x_nxt;
  logic [2:0] cnt_r;
  logic       busy_r;
  logic       done_r;
  logic       top_zero;
  logic [5:0] amt;

  always_comb begin
    unique case (cnt_r)
      3'd0: begin top_zero = ~|x_r.m[63:32]; amt = 6'd32; end
      3'd1: begin top_zero = ~|x_r.m[63:48]; amt = 6'd16; end
      3'd2: begin top_zero = ~|x_r.m[63:56]; amt = 6'd8;  end
      3'd3: begin top_zero = ~|x_r.m[63:60]; amt = 6'd4;  end
      3'd4: begin top_zero = ~|x_r.m[63:62]; amt = 6'd2;  end
      3'd5: begin top_zero = ~x_r.m[63];     amt = 6'd1;  end
      default: begin top_zero = 1'b0; amt = 6'd0; end
    endcase
    x_nxt = x_r;
    if (top_zero) begin
      x_nxt.m = x_r.m << amt;
      x_nxt.e = x_r.e - EXP_W'(amt);
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      x_r <= x_i;
    end else if (busy_r) begin
      x_r <= x_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 3'd1;
      if (cnt_r == 3'(STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign x_o    = x_r;
  assign busy_o = busy_r;
  assign done_o = done_r;

endmodule

// ----- src/bsdp_round.sv -----
// ============================================================================
// bsdp_round: single-precision rounder
// Rounds a normalised frame plus sticky bit to the nearest even single,
// covering subnormal results and overflow to infinity.
// ============================================================================
module bsdp_round (
  input  bsdp_pkg::bsdp_rnd_t r_i,
  output logic [31:0]         bits_o
);
  import bsdp_pkg::*;

  logic signed [EXP_W:0] biased;
  logic signed [EXP_W:0] sub_sh;
  logic                  normal;
  logic [6:0]            sh;
  logic [127:0]          wide;
  logic [FRAME_W-1:0]    kept;
  logic                  rnd;
  logic                  st;
  logic                  inc;
  logic [MANT_W:0]       rounded;
  logic [EXP_W:0]        expbase;
  logic [35:0]           total;

  always_comb begin
    biased = $signed({r_i.x.e[EXP_W-1], r_i.x.e}) + 13'sd127;
    normal = (biased > 13'sd0);
    sub_sh = 13'sd41 - biased;
    if (normal) begin
      sh = 7'd40;
    end else if (sub_sh > 13'sd127) begin
      sh = 7'd127;
    end else begin
      sh = sub_sh[6:0];
    end
    wide    = {r_i.x.m, 64'b0} >> sh;
    kept    = wide[127:64];
    rnd     = wide[63];
    st      = (|wide[62:0]) | r_i.sticky;
    inc     = rnd & (st | kept[0]);
    rounded = kept[MANT_W:0] + (MANT_W+1)'(inc);
    expbase = normal ? 13'(biased - 13'sd1) : '0;
    // A carry out of the mantissa moves into the exponent field by itself.
    total   = {expbase, 23'b0} + 36'(rounded);
    if (total[35:23] >= 13'd255) begin
      bits_o = {r_i.sign, EXP_MAX, 23'b0};
    end else begin
      bits_o = {r_i.sign, total[30:0]};
    end
  end

endmodule
